[design/tpd_pkg.sv]
// shared types and constants of the typed packet deframer
package tpd_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned TypeW = 4;
  localparam int unsigned LenW = 6;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned NumLenRegs = 5;
  localparam int unsigned MaxPayloadDef = 32;

  // fixed payload length of the short types (size of a short)
  localparam logic [LenW-1:0] ShortBytes = 6'd2;

  // packet type codes
  localparam logic [ByteW-1:0] TypeMin = 8'd1;
  localparam logic [ByteW-1:0] TypeLenMax = 8'd5;
  localparam logic [ByteW-1:0] TypeShortLo = 8'd6;
  localparam logic [ByteW-1:0] TypeShortHi = 8'd7;
  localparam logic [ByteW-1:0] TypeMax = 8'd10;

  // register indexes
  localparam logic [CfgIdxW-1:0] RegStartCode = 3'd0;
  localparam logic [CfgIdxW-1:0] RegEndCode = 3'd1;
  localparam logic [CfgIdxW-1:0] RegLenSpeed = 3'd2;
  localparam logic [CfgIdxW-1:0] RegLenBoard = 3'd3;
  localparam logic [CfgIdxW-1:0] RegLenCurrent = 3'd4;
  localparam logic [CfgIdxW-1:0] RegLenSensors = 3'd5;
  localparam logic [CfgIdxW-1:0] RegLenEncoder = 3'd6;

  // configuration register file contents
  typedef struct packed {
    logic [ByteW-1:0]                 start_code;
    logic [ByteW-1:0]                 end_code;
    logic [NumLenRegs-1:0][LenW-1:0]  len;
  } cfg_t;

  // payload store write request
  typedef struct packed {
    logic             en;
    logic             bank;
    logic [LenW-1:0]  idx;
    logic [ByteW-1:0] data;
  } mem_wr_t;

  // completed frame handed from front to back
  typedef struct packed {
    logic             bank;
    logic [TypeW-1:0] htype;
    logic [LenW-1:0]  len;
  } desc_t;

endpackage

[design/typed_packet_deframer_top.sv]
// typed packet deframer top level: register file, parser, frame queue, emitter
// Every received byte is taken when push is high and full is low; the type byte of a good frame
// is registered in the frame queue, then in the output queue, after its end byte is taken; payload
// bytes follow, and the two-entry output queue reserves a slot for the store read in flight.
// Input stalls (full high) while two completed frames wait; the store has two banks.
// Asynchronous active-low reset clears registers to 0, parser to hunt, queues to empty;
// the payload store is not cleared.
module typed_packet_deframer_top import tpd_pkg::*; #(
  parameter int unsigned MaxPayload = MaxPayloadDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [ByteW-1:0]   cfg_data_i,
  input  logic               push,
  output logic               full,
  input  logic [ByteW-1:0]   rx_byte_i,
  output logic               empty,
  input  logic               pop,
  output logic [ByteW-1:0]   out_byte_o,
  output logic               is_type_o,
  output logic               last_o
);

  cfg_t       cfg_q;
  mem_wr_t    mem_wr;
  logic       desc_push, desc_pop;
  desc_t      desc_in, desc_head;
  logic [1:0] desc_cnt;
  logic       accept;

  assign full   = (desc_cnt == 2'd2);
  assign accept = push && !full;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegStartCode:  cfg_q.start_code <= cfg_data_i;
        RegEndCode:    cfg_q.end_code   <= cfg_data_i;
        RegLenSpeed:   cfg_q.len[0]     <= cfg_data_i[LenW-1:0];
        RegLenBoard:   cfg_q.len[1]     <= cfg_data_i[LenW-1:0];
        RegLenCurrent: cfg_q.len[2]     <= cfg_data_i[LenW-1:0];
        RegLenSensors: cfg_q.len[3]     <= cfg_data_i[LenW-1:0];
        RegLenEncoder: cfg_q.len[4]     <= cfg_data_i[LenW-1:0];
        default: ;
      endcase
    end
  end

  // frame parser
  tpd_front #(.MaxPayload(MaxPayload)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .rx_byte_i   (rx_byte_i),
    .cfg_i       (cfg_q),
    .mem_wr_o    (mem_wr),
    .desc_push_o (desc_push),
    .desc_o      (desc_in)
  );

  // completed frame queue
  tpd_desc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (desc_push),
    .desc_i  (desc_in),
    .pop_i   (desc_pop),
    .head_o  (desc_head),
    .count_o (desc_cnt)
  );

  // frame emitter
  tpd_back #(.MaxPayload(MaxPayload)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .mem_wr_i     (mem_wr),
    .desc_valid_i (desc_cnt != 2'd0),
    .desc_i       (desc_head),
    .desc_pop_o   (desc_pop),
    .pop          (pop),
    .empty        (empty),
    .out_byte_o   (out_byte_o),
    .is_type_o    (is_type_o),
    .last_o       (last_o)
  );

`ifndef ASSERT_OFF
  // frame queue never holds more than its two banks
  a_desc_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    desc_cnt != 2'd3) else $error("frame queue overflow");

  // parser only completes a frame when a bank is free
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    desc_push |-> desc_cnt != 2'd2) else $error("frame pushed while full");

  // emitter only retires a frame that is pending
  a_pop_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    desc_pop |-> desc_cnt != 2'd0) else $error("frame popped while empty");

  // no store write lands in a bank still being emitted when both are pending
  a_no_write_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_wr.en |-> !full) else $error("payload write while both banks busy");
`endif

endmodule

[design/tpd_front.sv]
// frame parser: hunts start code, checks type, stores payload, checks end code
module tpd_front import tpd_pkg::*; #(
  parameter int unsigned MaxPayload = MaxPayloadDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [ByteW-1:0] rx_byte_i,
  input  cfg_t             cfg_i,
  output mem_wr_t          mem_wr_o,
  output logic             desc_push_o,
  output desc_t            desc_o
);

  typedef enum logic [1:0] {
    PhHunt,
    PhType,
    PhData
  } phase_e;

  phase_e           phase_q, phase_d;
  logic [TypeW-1:0] htype_q, htype_d;
  logic [LenW-1:0]  len_q, len_d;
  logic [LenW-1:0]  rem_q, rem_d;
  logic [LenW-1:0]  idx_q, idx_d;
  logic             bank_q, bank_d;
  logic [LenW-1:0]  raw_len;
  logic [LenW-1:0]  type_len;
  logic [2:0]       len_sel;

  // payload length from the type byte, saturated to the store size
  assign len_sel = rx_byte_i[2:0] - 3'd1;
  always_comb begin
    if (rx_byte_i >= TypeMin && rx_byte_i <= TypeLenMax) begin
      raw_len = cfg_i.len[len_sel];
    end else if (rx_byte_i == TypeShortLo || rx_byte_i == TypeShortHi) begin
      raw_len = ShortBytes;
    end else begin
      raw_len = '0;
    end
    type_len = (raw_len > LenW'(MaxPayload)) ? LenW'(MaxPayload) : raw_len;
  end

  // next state of the parser
  always_comb begin
    phase_d     = phase_q;
    htype_d     = htype_q;
    len_d       = len_q;
    rem_d       = rem_q;
    idx_d       = idx_q;
    bank_d      = bank_q;
    mem_wr_o    = '0;
    desc_push_o = 1'b0;
    if (accept_i) begin
      unique case (phase_q)
        PhType: begin
          if (rx_byte_i >= TypeMin && rx_byte_i <= TypeMax) begin
            htype_d = rx_byte_i[TypeW-1:0];
            len_d   = type_len;
            rem_d   = type_len;
            idx_d   = '0;
            phase_d = PhData;
          end else begin
            phase_d = PhHunt;
          end
        end
        PhData: begin
          if (rem_q != '0) begin
            mem_wr_o.en   = 1'b1;
            mem_wr_o.bank = bank_q;
            mem_wr_o.idx  = idx_q;
            mem_wr_o.data = rx_byte_i;
            idx_d = idx_q + LenW'(1);
            rem_d = rem_q - LenW'(1);
          end else begin
            if (rx_byte_i == cfg_i.end_code) begin
              desc_push_o = 1'b1;
              bank_d      = ~bank_q;
            end
            phase_d = PhHunt;
          end
        end
        default: begin
          phase_d = (rx_byte_i == cfg_i.start_code) ? PhType : PhHunt;
        end
      endcase
    end
  end

  assign desc_o = '{bank: bank_q, htype: htype_q, len: len_q};

  // parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhHunt;
      htype_q <= '0;
      len_q   <= '0;
      rem_q   <= '0;
      idx_q   <= '0;
      bank_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      htype_q <= htype_d;
      len_q   <= len_d;
      rem_q   <= rem_d;
      idx_q   <= idx_d;
      bank_q  <= bank_d;
    end
  end

endmodule

[design/tpd_desc_queue.sv]
// two-entry queue of completed frames between parser and emitter
module tpd_desc_queue import tpd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  desc_t      desc_i,
  input  logic       pop_i,
  output desc_t      head_o,
  output logic [1:0] count_o
);

  desc_t      ent_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;

  assign head_o  = ent_q[rptr_q];
  assign count_o = cnt_q;

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wptr_q] <= desc_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= ~wptr_q;
      end
      if (pop_i) begin
        rptr_q <= ~rptr_q;
      end
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

endmodule

[design/tpd_back.sv]
// emitter: double-banked payload store, frame readout and output queue
module tpd_back import tpd_pkg::*; #(
  parameter int unsigned MaxPayload = MaxPayloadDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  mem_wr_t          mem_wr_i,
  input  logic             desc_valid_i,
  input  desc_t            desc_i,
  output logic             desc_pop_o,
  input  logic             pop,
  output logic             empty,
  output logic [ByteW-1:0] out_byte_o,
  output logic             is_type_o,
  output logic             last_o
);

  localparam int unsigned IdxW = $clog2(MaxPayload);
  localparam int unsigned Depth = 2 ** (IdxW + 1);

  typedef enum logic {
    BIdle,
    BPayload
  } bstate_e;

  bstate_e          state_q, state_d;
  logic [LenW-1:0]  rd_idx_q, rd_idx_d;
  logic             inflight_q, inflight_last_q, inflight_last_d;
  logic             rd_en;
  logic [ByteW-1:0] rdata_q;
  logic [ByteW-1:0] mem [Depth];

  logic [ByteW-1:0] ent_byte_q [2];
  logic             ent_type_q [2];
  logic             ent_last_q [2];
  logic             wptr_q, rptr_q;
  logic [1:0]       cnt_q;
  logic             space;
  logic             push_en, push_type, push_last;
  logic [ByteW-1:0] push_byte;
  logic             out_pop;
  logic [LenW-1:0]  rd_next;
  logic             rd_last;

  // room in the output queue counting a read still in flight
  assign space   = (cnt_q + 2'(inflight_q)) < 2'd2;
  assign rd_next = rd_idx_q + LenW'(1);
  assign rd_last = (rd_next == desc_i.len);
  assign out_pop = pop && (cnt_q != '0);

  // readout sequencer
  always_comb begin
    state_d         = state_q;
    rd_idx_d        = rd_idx_q;
    rd_en           = 1'b0;
    inflight_last_d = inflight_last_q;
    desc_pop_o      = 1'b0;
    push_en         = inflight_q;
    push_byte       = rdata_q;
    push_type       = 1'b0;
    push_last       = inflight_last_q;
    unique case (state_q)
      BIdle: begin
        if (desc_valid_i && space && !inflight_q) begin
          push_en   = 1'b1;
          push_byte = ByteW'(desc_i.htype);
          push_type = 1'b1;
          push_last = (desc_i.len == '0);
          rd_idx_d  = '0;
          if (desc_i.len == '0) begin
            desc_pop_o = 1'b1;
          end else begin
            state_d = BPayload;
          end
        end
      end
      BPayload: begin
        if (space) begin
          rd_en           = 1'b1;
          rd_idx_d        = rd_next;
          inflight_last_d = rd_last;
          if (rd_last) begin
            desc_pop_o = 1'b1;
            state_d    = BIdle;
          end
        end
      end
      default: begin
        state_d = BIdle;
      end
    endcase
  end

  // payload store, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_wr_i.en) begin
      mem[{mem_wr_i.bank, mem_wr_i.idx[IdxW-1:0]}] <= mem_wr_i.data;
    end
    if (rd_en) begin
      rdata_q <= mem[{desc_i.bank, rd_idx_q[IdxW-1:0]}];
    end
  end

  // output queue entries
  always_ff @(posedge clk_i) begin
    if (push_en) begin
      ent_byte_q[wptr_q] <= push_byte;
      ent_type_q[wptr_q] <= push_type;
      ent_last_q[wptr_q] <= push_last;
    end
  end

  // sequencer state and output queue control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= BIdle;
      rd_idx_q        <= '0;
      inflight_q      <= 1'b0;
      inflight_last_q <= 1'b0;
      wptr_q          <= 1'b0;
      rptr_q          <= 1'b0;
      cnt_q           <= '0;
    end else begin
      state_q         <= state_d;
      rd_idx_q        <= rd_idx_d;
      inflight_q      <= rd_en;
      inflight_last_q <= inflight_last_d;
      if (push_en) begin
        wptr_q <= ~wptr_q;
      end
      if (out_pop) begin
        rptr_q <= ~rptr_q;
      end
      cnt_q <= cnt_q + 2'(push_en) - 2'(out_pop);
    end
  end

  assign empty      = (cnt_q == '0);
  assign out_byte_o = ent_byte_q[rptr_q];
  assign is_type_o  = ent_type_q[rptr_q];
  assign last_o     = ent_last_q[rptr_q];

endmodule

[tb/typed_packet_deframer_top_tb.sv]
`timescale 1ns / 1ps
// self-checking testbench of the typed packet deframer: byte stream in, typed packets out
module typed_packet_deframer_top_tb;
  import tpd_pkg::*;

  localparam logic [CfgIdxW-1:0] RegUnused = 3'd7;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned HoldCycles = 300;

  typedef enum logic [1:0] {PhHunt, PhType, PhCollect} frame_phase_e;

  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             is_type;
    logic             last;
  } packet_byte_t;

  typedef logic [NumLenRegs-1:0][ByteW-1:0] len_set_t;

  // predicts emitted packet bytes from the accepted byte stream and checks the output
  class frame_scoreboard;
    logic [ByteW-1:0] start_code;
    logic [ByteW-1:0] end_code;
    logic [LenW-1:0]  len_reg [NumLenRegs];
    frame_phase_e     phase;
    logic [TypeW-1:0] held_type;
    logic [LenW-1:0]  remaining;
    logic [LenW-1:0]  plen;
    logic [ByteW-1:0] store [MaxPayloadDef];
    packet_byte_t     pending_bytes [$];
    int unsigned      errors;
    int unsigned      frames;
    int unsigned      checked;

    function new();
      start_code = '0;
      end_code = '0;
      foreach (len_reg[i]) len_reg[i] = '0;
      phase = PhHunt;
      held_type = '0;
      remaining = '0;
      plen = '0;
      errors = 0;
      frames = 0;
      checked = 0;
    endfunction

    task report(input string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    function void config_write(input logic [CfgIdxW-1:0] idx, input logic [ByteW-1:0] data);
      case (idx)
        RegStartCode: start_code = data;
        RegEndCode: end_code = data;
        RegLenSpeed, RegLenBoard, RegLenCurrent, RegLenSensors, RegLenEncoder:
          len_reg[idx - RegLenSpeed] = data[LenW-1:0];
        default: ;
      endcase
    endfunction

    // payload length of a packet type, saturated to the store size
    function logic [LenW-1:0] frame_length(input logic [ByteW-1:0] t);
      int unsigned n;
      if (t >= TypeMin && t <= TypeLenMax) n = len_reg[t - TypeMin];
      else if (t == TypeShortLo || t == TypeShortHi) n = ShortBytes;
      else n = 0;
      if (n > MaxPayloadDef) n = MaxPayloadDef;
      return LenW'(n);
    endfunction

    function void note_byte(input logic [ByteW-1:0] b);
      packet_byte_t pb;
      case (phase)
        PhType: begin
          if (b >= TypeMin && b <= TypeMax) begin
            held_type = b[TypeW-1:0];
            plen = frame_length(b);
            remaining = plen;
            phase = PhCollect;
          end else begin
            phase = PhHunt;
          end
        end
        PhCollect: begin
          if (remaining > 0) begin
            store[plen - remaining] = b;
            remaining--;
          end else begin
            // end byte: emit type then payload only on a matching end code
            if (b == end_code) begin
              pb.data = ByteW'(held_type);
              pb.is_type = 1'b1;
              pb.last = (plen == 0);
              pending_bytes.push_back(pb);
              for (int i = 0; i < plen; i++) begin
                pb.data = store[i];
                pb.is_type = 1'b0;
                pb.last = (i + 1 == plen);
                pending_bytes.push_back(pb);
              end
              frames++;
            end
            phase = PhHunt;
          end
        end
        default: phase = (b == start_code) ? PhType : PhHunt;
      endcase
    endfunction

    task check_result(input logic [ByteW-1:0] ob, input logic it, input logic lst);
      packet_byte_t want;
      if (pending_bytes.size() == 0) begin
        report($sformatf("unexpected output byte %02h is_type %b last %b", ob, it, lst));
      end else begin
        want = pending_bytes.pop_front();
        checked++;
        if (ob !== want.data)
          report($sformatf("out_byte %02h, expected %02h", ob, want.data));
        if (it !== want.is_type)
          report($sformatf("is_type %b, expected %b (byte %02h)", it, want.is_type, want.data));
        if (lst !== want.last)
          report($sformatf("last %b, expected %b (byte %02h)", lst, want.last, want.data));
      end
    endtask
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [ByteW-1:0]   cfg_data_i = '0;
  logic               push = 1'b0;
  logic               full;
  logic [ByteW-1:0]   rx_byte_i = '0;
  logic               empty;
  logic               pop = 1'b0;
  logic [ByteW-1:0]   out_byte_o;
  logic               is_type_o;
  logic               last_o;

  frame_scoreboard sb = new();
  int unsigned     idle_pct = 7;
  int unsigned     bytes_sent = 0;
  int unsigned     configs = 0;
  int unsigned     stuck_cycles = 0;
  logic            hold_req = 1'b0;

  typed_packet_deframer_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .push       (push),
    .full       (full),
    .rx_byte_i  (rx_byte_i),
    .empty      (empty),
    .pop        (pop),
    .out_byte_o (out_byte_o),
    .is_type_o  (is_type_o),
    .last_o     (last_o)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // no request moved for too long means the block hung
  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
      if (stuck_cycles >= WatchdogLimit) begin
        $display("watchdog: no request moved for %0d cycles", WatchdogLimit);
        $display("typed_packet_deframer_top regression: fail");
        $finish;
      end
    end
  end

  // result side: check accepted bytes, random pop with an optional long hold-off
  initial begin : result_sink
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && pop && !empty) sb.check_result(out_byte_o, is_type_o, last_o);
      if (hold_req) begin
        hold_left = HoldCycles;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        pop <= 1'b0;
        hold_left--;
      end else begin
        pop <= ($urandom_range(99) >= idle_pct);
      end
    end
  end

  task automatic send_byte(input logic [ByteW-1:0] b);
    while ($urandom_range(99) < idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    rx_byte_i <= b;
    do @(posedge clk_i); while (full);
    sb.note_byte(b);
    bytes_sent++;
  endtask

  // wait for every expected byte, then let the back end settle
  task automatic quiesce();
    push <= 1'b0;
    while (sb.pending_bytes.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [ByteW-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    sb.config_write(idx, data);
  endtask

  task automatic write_config(input logic [ByteW-1:0] start_v, input logic [ByteW-1:0] end_v,
                              input len_set_t lens);
    // the unused index must leave every register alone
    write_reg(RegUnused, ByteW'($urandom));
    write_reg(RegStartCode, start_v);
    write_reg(RegEndCode, end_v);
    for (int i = 0; i < NumLenRegs; i++) write_reg(CfgIdxW'(RegLenSpeed + i), lens[i]);
    cfg_we_i <= 1'b0;
    configs++;
  endtask

  function automatic len_set_t random_lens(input int unsigned top);
    len_set_t l;
    for (int i = 0; i < NumLenRegs; i++) l[i] = ByteW'($urandom_range(top));
    return l;
  endfunction

  // mostly well-formed frames with random content, some noise, bad types and bad end bytes
  task automatic random_phase(input int unsigned quota);
    int unsigned stop_at;
    int unsigned pick;
    logic [ByteW-1:0] ftype;
    stop_at = bytes_sent + quota;
    while (bytes_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 10) begin
        send_byte(ByteW'($urandom));
      end else begin
        while (sb.phase != PhHunt) send_byte(ByteW'($urandom));
        send_byte(sb.start_code);
        if (pick < 20) begin
          ftype = ($urandom_range(1) == 0) ? 8'd0 : ByteW'($urandom_range(255, 11));
          send_byte(ftype);
        end else begin
          ftype = ByteW'($urandom_range(TypeMax, TypeMin));
          send_byte(ftype);
          repeat (sb.plen) send_byte(ByteW'($urandom));
          if (pick < 30) send_byte(sb.end_code ^ ByteW'($urandom_range(255, 1)));
          else send_byte(sb.end_code);
        end
      end
    end
    quiesce();
  endtask

  initial begin : stimulus
    logic [ByteW-1:0] seq [$];
    len_set_t lens;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: empty payload, start code as type, short type with start code in payload,
    // type above range, wrong end byte
    seq = '{8'h00, 8'h01, 8'h00,
            8'h00, 8'h00, 8'h00, 8'h07, 8'h11, 8'h22, 8'h00,
            8'h00, 8'h0B,
            8'h00, 8'h0A, 8'h5A,
            8'h00, 8'h06, 8'h00, 8'hFF, 8'h00};
    foreach (seq[i]) send_byte(seq[i]);
    quiesce();

    // length latched at the type byte survives register writes mid-frame
    lens = '0;
    lens[0] = 8'hC3;
    write_config(8'hFF, 8'h80, lens);
    send_byte(8'hFF);
    send_byte(8'h01);
    quiesce();
    write_config(8'hFF, 8'h7E, '0);
    seq = '{8'hA1, 8'hB2, 8'hC3, 8'h7E};
    foreach (seq[i]) send_byte(seq[i]);
    quiesce();

    // minimum lengths, extreme codes
    write_config(8'h00, 8'hFF, '0);
    random_phase(40);

    // longest payload on one type
    lens = random_lens(3);
    lens[0] = 8'd32;
    write_config(8'hFF, 8'h00, lens);
    random_phase(50);

    // receiver holds off so the block fills and stalls the input
    write_config(ByteW'($urandom), ByteW'($urandom), random_lens(4));
    hold_req = 1'b1;
    random_phase(40);

    // no idling on either side, start and end code equal
    idle_pct = 0;
    seq = '{ByteW'($urandom)};
    write_config(seq[0], seq[0], random_lens(7));
    random_phase(40);
    idle_pct = 7;

    // lengths above the store size saturate, upper data bits are dropped
    lens = {8'd4, 8'd1, 8'hC2, 8'd33, 8'd63};
    write_config(ByteW'($urandom), ByteW'($urandom), lens);
    random_phase(45);

    write_config(ByteW'($urandom), ByteW'($urandom), random_lens(10));
    random_phase(40);

    $display("covered %0d received bytes under %0d register settings", bytes_sent, configs);
    $display("%0d packets and %0d packet bytes compared", sb.frames, sb.checked);
    if (sb.errors == 0) begin
      $display("typed_packet_deframer_top regression: pass");
    end else begin
      $display("typed_packet_deframer_top regression: fail");
    end
    $finish;
  end

endmodule
